// ===== design/per_bin_moving_average_macros.svh =====
// Assertion macros shared by the per-bin moving average RTL.
`ifndef PER_BIN_MOVING_AVERAGE_MACROS_SVH
`define PER_BIN_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PBMA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PBMA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pbma_pkg.sv =====
// Shared constants and types for the per-bin moving average.
package pbma_pkg;

   localparam int BINS           = 1024;
   localparam int BIN_WIDTH      = $clog2(BINS);
   localparam int DEPTH_MAX      = 64;
   localparam int SLOT_WIDTH     = $clog2(DEPTH_MAX);
   localparam int FILL_WIDTH     = SLOT_WIDTH + 1;
   localparam int SAMPLE_WIDTH   = 32;
   localparam int SUM_WIDTH      = SAMPLE_WIDTH + FILL_WIDTH - 1;
   localparam int GAIN_WIDTH     = 16;
   localparam int GAIN_FRAC      = 8;
   localparam int DIVISOR_WIDTH  = FILL_WIDTH + GAIN_WIDTH;
   localparam int DIVIDEND_WIDTH = SUM_WIDTH + GAIN_FRAC;
   localparam int DIV_CNT_WIDTH  = $clog2(DIVIDEND_WIDTH);
   localparam int WIN_ENTRIES    = BINS * DEPTH_MAX;
   localparam int WIN_ADDR_WIDTH = BIN_WIDTH + SLOT_WIDTH;

   localparam logic [FILL_WIDTH-1:0] DEPTH_LIMIT = FILL_WIDTH'(DEPTH_MAX);
   localparam logic [FILL_WIDTH-1:0] DEPTH_RESET = FILL_WIDTH'(1);
   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET  = GAIN_WIDTH'(256);

   // saturation limits of the quotient magnitude
   localparam logic [DIVIDEND_WIDTH-1:0] SAT_POS =
      (DIVIDEND_WIDTH'(1) << (SAMPLE_WIDTH - 1)) - DIVIDEND_WIDTH'(1);
   localparam logic [DIVIDEND_WIDTH-1:0] SAT_NEG =
      DIVIDEND_WIDTH'(1) << (SAMPLE_WIDTH - 1);

   typedef struct packed {
      logic [SLOT_WIDTH-1:0]       oldest;
      logic [FILL_WIDTH-1:0]       fill;
      logic signed [SUM_WIDTH-1:0] sum;
      logic [FILL_WIDTH-1:0]       count;
   } bin_state_type;

   typedef struct packed {
      logic                           missing;
      logic signed [SAMPLE_WIDTH-1:0] value;
   } win_entry_type;

   typedef struct packed {
      logic                      start;
      logic [DIVIDEND_WIDTH-1:0] dividend;
      logic [DIVISOR_WIDTH-1:0]  divisor;
   } div_in_type;

   typedef struct packed {
      logic                      done;
      logic [DIVIDEND_WIDTH-1:0] quotient;
   } div_out_type;

endpackage

// ===== design/pbma_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`include "per_bin_moving_average_macros.svh"

module pbma_divider import pbma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_in_type  div_in,
   output div_out_type div_out
);

   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(DIVIDEND_WIDTH - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_WIDTH:0] trial;
   logic [DIVISOR_WIDTH:0] diff;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_in.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_LAST;
         rem_in  = '0;
         quo_in  = div_in.dividend;
         dsr_in  = div_in.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_WIDTH'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_out.done     = done_ff;
   assign div_out.quotient = quo_ff;

   `PBMA_ASSERT_IMP(a_no_restart, busy_ff, !div_in.start, "divider restarted while busy")
   `PBMA_ASSERT_NXT(a_start_busy, div_in.start, busy_ff, "divider did not go busy")
   `PBMA_ASSERT_NXT(a_done_pulse, done_ff, !done_ff && !busy_ff, "done is not a single pulse")

endmodule

// ===== design/per_bin_moving_average.sv =====
// Per-bin sliding-window moving average, top level.
//
// Usage:
//  req_*: one transaction pushes sample (Q16.16, or missing) into the window of req_bin.
//  rsp_*: one transaction per request, in order: the bin, its new average
//         sum / (count * gain) in Q16.16 truncated toward zero and saturated,
//         0 when count or gain is 0, and the number of counted samples.
//  csr_*: index 0 writes window_depth from csr_wdata[6:0] (0 acts as 1, above
//         64 acts as 64), index 1 writes gain (unsigned Q8.8). csr_ready is
//         always high; write only while no request is in flight.
// Flow: one request at a time. A request passes bin read, window update, the
//  46-step bit-serial divider and the output register; each old entry dropped
//  from the window adds a read of the single-port window memory.
//  req_ready is high only in the idle state.
// Reset: per-bin state is zeroed by a clearing pass over all 1024 bins (one bin per
//  cycle); req_ready stays low meanwhile, CSR writes are taken.
// Stall: a finished result waits in the rsp register; the next request is
//  accepted and processed meanwhile and holds its result until rsp frees up.
`include "per_bin_moving_average_macros.svh"

module per_bin_moving_average import pbma_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [BIN_WIDTH-1:0]           req_bin,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_sample_missing,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [BIN_WIDTH-1:0]           rsp_bin_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_average,
   output logic [FILL_WIDTH-1:0]          rsp_counted,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [0:0]                     csr_index,
   input  logic [GAIN_WIDTH-1:0]          csr_wdata
);

   // register indexes
   localparam logic [0:0] CSR_DEPTH = 1'b0;
   localparam logic [0:0] CSR_GAIN  = 1'b1;

   // sequencer states
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_BIN_RD    = 3'd2;
   localparam logic [2:0] ST_STEP      = 3'd3;
   localparam logic [2:0] ST_DROP_WAIT = 3'd4;
   localparam logic [2:0] ST_DIV_START = 3'd5;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd6;
   localparam logic [2:0] ST_OUT       = 3'd7;

   localparam logic [BIN_WIDTH-1:0] BIN_LAST = BIN_WIDTH'(BINS - 1);

   logic [2:0]            state_ff, state_in;
   logic [BIN_WIDTH-1:0]  clr_addr_ff, clr_addr_in;
   logic [FILL_WIDTH-1:0] depth_ff, depth_in;
   logic [GAIN_WIDTH-1:0] gain_ff, gain_in;
   logic                  pushed_ff, pushed_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // transaction payload and per-bin working copy
   logic [BIN_WIDTH-1:0]           bin_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                           missing_ff;
   logic [SLOT_WIDTH-1:0]          oldest_ff, oldest_in;
   logic [FILL_WIDTH-1:0]          fill_ff, fill_in;
   logic signed [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [FILL_WIDTH-1:0]          count_ff, count_in;
   logic                           neg_ff, neg_in;
   logic signed [SAMPLE_WIDTH-1:0] avg_ff, avg_in;
   logic [BIN_WIDTH-1:0]           rsp_bin_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_avg_ff;
   logic [FILL_WIDTH-1:0]          rsp_cnt_ff;

   // memories
   bin_state_type bin_mem [BINS];
   bin_state_type bin_rd_ff;
   logic          bin_we;
   logic [BIN_WIDTH-1:0] bin_waddr;
   bin_state_type bin_wdata;

   win_entry_type win_mem [WIN_ENTRIES];
   win_entry_type win_rd_ff;
   logic          win_we, win_re;
   logic [WIN_ADDR_WIDTH-1:0] win_addr;
   win_entry_type win_wdata;

   logic                  req_accept;
   logic                  rsp_load;
   logic [FILL_WIDTH-1:0] depth_eff;
   logic                  drop_due;

   // shared sum adder: add on push, subtract on drop
   logic                        sum_sub;
   logic signed [SUM_WIDTH-1:0] sum_opnd;
   logic signed [SUM_WIDTH-1:0] sum_res;

   logic [SUM_WIDTH-1:0]      sum_mag;
   logic [DIVIDEND_WIDTH-1:0] quo_lim;
   logic [DIVIDEND_WIDTH-1:0] quo_sat;

   div_in_type  div_in;
   div_out_type div_out;
   div_in_type  div_in_go;
   logic        div_go;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = FILL_WIDTH'(1);
      end else if (depth_ff > DEPTH_LIMIT) begin
         depth_eff = DEPTH_LIMIT;
      end else begin
         depth_eff = depth_ff;
      end
   end

   // a full ring loses its oldest entry before the push; after it, entries over the depth go
   assign drop_due = pushed_ff ? (fill_ff > depth_eff) : (fill_ff == DEPTH_LIMIT);

   assign sum_sub  = (state_ff == ST_DROP_WAIT);
   assign sum_opnd = sum_sub ? SUM_WIDTH'(win_rd_ff.value)
                             : (missing_ff ? '0 : SUM_WIDTH'(sample_ff));
   assign sum_res  = sum_ff + (sum_opnd ^ {SUM_WIDTH{sum_sub}}) + SUM_WIDTH'(sum_sub);

   assign sum_mag = sum_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_ff) : SUM_WIDTH'(sum_ff);

   assign quo_lim = neg_ff ? SAT_NEG : SAT_POS;
   assign quo_sat = (div_out.quotient > quo_lim) ? quo_lim : div_out.quotient;

   always_comb begin
      div_in.start    = 1'b0;
      div_in.dividend = {sum_mag, GAIN_FRAC'(0)};
      div_in.divisor  = DIVISOR_WIDTH'(count_ff) * DIVISOR_WIDTH'(gain_ff);
   end

   pbma_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in_go),
      .div_out (div_out)
   );

   always_comb begin
      div_in_go       = div_in;
      div_in_go.start = div_go;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      pushed_in   = pushed_ff;
      oldest_in   = oldest_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      neg_in      = neg_ff;
      avg_in      = avg_ff;
      bin_we      = 1'b0;
      bin_waddr   = bin_ff;
      bin_wdata   = '{oldest: oldest_ff, fill: fill_ff, sum: sum_ff, count: count_ff};
      win_we      = 1'b0;
      win_re      = 1'b0;
      win_addr    = {bin_ff, oldest_ff};
      win_wdata   = '{missing: missing_ff, value: missing_ff ? '0 : sample_ff};
      div_go      = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            bin_we      = 1'b1;
            bin_waddr   = clr_addr_ff;
            bin_wdata   = '0;
            clr_addr_in = clr_addr_ff + BIN_WIDTH'(1);
            if (clr_addr_ff == BIN_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BIN_RD;
            end
         end
         ST_BIN_RD: begin
            oldest_in = bin_rd_ff.oldest;
            fill_in   = bin_rd_ff.fill;
            sum_in    = bin_rd_ff.sum;
            count_in  = bin_rd_ff.count;
            pushed_in = 1'b0;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (drop_due) begin
               win_re   = 1'b1;
               state_in = ST_DROP_WAIT;
            end else if (!pushed_ff) begin
               win_we    = 1'b1;
               win_addr  = {bin_ff, oldest_ff + fill_ff[SLOT_WIDTH-1:0]};
               fill_in   = fill_ff + FILL_WIDTH'(1);
               sum_in    = sum_res;
               count_in  = count_ff + FILL_WIDTH'(!missing_ff);
               pushed_in = 1'b1;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DROP_WAIT: begin
            sum_in    = sum_res;
            count_in  = count_ff - FILL_WIDTH'(!win_rd_ff.missing);
            oldest_in = oldest_ff + SLOT_WIDTH'(1);
            fill_in   = fill_ff - FILL_WIDTH'(1);
            state_in  = ST_STEP;
         end
         ST_DIV_START: begin
            bin_we = 1'b1;
            neg_in = sum_ff[SUM_WIDTH-1];
            if (count_ff == '0 || gain_ff == '0) begin
               avg_in   = '0;
               state_in = ST_OUT;
            end else begin
               div_go   = 1'b1;
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_out.done) begin
               avg_in   = neg_ff ? -SAMPLE_WIDTH'(quo_sat) : SAMPLE_WIDTH'(quo_sat);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration
   always_comb begin
      depth_in = depth_ff;
      gain_in  = gain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEPTH: depth_in = csr_wdata[FILL_WIDTH-1:0];
            CSR_GAIN:  gain_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         depth_ff     <= DEPTH_RESET;
         gain_ff      <= GAIN_RESET;
         pushed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         depth_ff     <= depth_in;
         gain_ff      <= gain_in;
         pushed_ff    <= pushed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bin_ff     <= req_bin;
         sample_ff  <= req_sample;
         missing_ff <= req_sample_missing;
      end
      oldest_ff <= oldest_in;
      fill_ff   <= fill_in;
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
      if (rsp_load) begin
         rsp_bin_ff <= bin_ff;
         rsp_avg_ff <= avg_ff;
         rsp_cnt_ff <= count_ff;
      end
   end

   // per-bin state memory, read at accept
   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (req_accept) begin
         bin_rd_ff <= bin_mem[req_bin];
      end
   end

   // window sample memory, one access per cycle
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_addr] <= win_wdata;
      end
      if (win_re) begin
         win_rd_ff <= win_mem[win_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bin_out = rsp_bin_ff;
   assign rsp_average = rsp_avg_ff;
   assign rsp_counted = rsp_cnt_ff;

   `PBMA_ASSERT_NXT(a_accept_busy, req_accept, state_ff == ST_BIN_RD,
                    "request transaction did not start the sequencer")
   `PBMA_ASSERT_IMP(a_window_fits, state_ff == ST_DIV_START,
                    fill_ff <= depth_eff && count_ff <= fill_ff,
                    "window over depth or count over fill after update")
   `PBMA_ASSERT_IMP(a_div_owner, div_out.done, state_ff == ST_DIV_WAIT,
                    "divider finished outside the wait state")
   `PBMA_ASSERT_IMP(a_rsp_free, rsp_load, !rsp_valid_ff || rsp_ready,
                    "result overwritten while the rsp transaction was pending")

endmodule
